// ===== hw/rtl/idd_pkg.sv =====
// Package for the isotropic diffusion denoise core.
// Holds sequencer states, command codes and result kinds. No dependencies.
`default_nettype none
package idd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_ACK,
    ST_COPY,
    ST_STEN,
    ST_MUL,
    ST_WR
  } state_t;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  localparam logic [1:0] REG_KAPPA  = 2'd0;
  localparam logic [1:0] REG_SWEEPS = 2'd1;
  localparam logic [1:0] REG_ROWS   = 2'd2;
  localparam logic [1:0] REG_COLS   = 2'd3;

  // stencil taps, issued in this order
  localparam logic [2:0] TAP_CENTER = 3'd0;
  localparam logic [2:0] TAP_UP     = 3'd1;
  localparam logic [2:0] TAP_LEFT   = 3'd2;
  localparam logic [2:0] TAP_RIGHT  = 3'd3;
  localparam logic [2:0] TAP_DOWN   = 3'd4;
  localparam logic [2:0] TAP_DONE   = 3'd5;

endpackage
`default_nettype wire

// ===== hw/rtl/idd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module idd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/isotropic_diffusion_denoise_core.sv =====
// Top level of the isotropic diffusion denoise core: sequencer, stencil
// datapath and two frame stores. Uses idd_pkg and idd_ram.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------
//   in      | into core | in_valid/in_stall  | cmd, pixel_in
//   out     | from core | out_valid/out_stall| kind, pixel_out, last_pixel
//   cfg     | into core | cfg_we             | cfg_index, cfg_data
//
// A load is written from the idle state; a read passes through the read-wait
// state, which waits for the output slot. A run makes one copy pass over the
// frame, then steps each interior pixel through the STEN, MUL and WR states
// via the single frame read port and the shared accumulator/multiplier.
// in_stall is high whenever the sequencer is not idle. Reset is synchronous;
// frame stores have no reset, only their index and select registers do.
`default_nettype none
module isotropic_diffusion_denoise_core #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_COLS  = 256,
  parameter int FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  pixel_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       pixel_out,
  output logic             last_pixel,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int PW    = 8 + FRAC_BITS;     // stored pixel width
  localparam int ACW   = PW + 3;            // signed laplacian
  localparam int PRW   = ACW + 16;          // kappa * laplacian

  // configuration registers
  logic [14:0] kappa;
  logic [9:0]  sweeps;
  logic [8:0]  rows;
  logic [8:0]  cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      kappa  <= 15'd1638;
      sweeps <= 10'd10;
      rows   <= 9'd256;
      cols   <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        idd_pkg::REG_KAPPA:  kappa  <= cfg_data;
        idd_pkg::REG_SWEEPS: sweeps <= cfg_data[9:0];
        idd_pkg::REG_ROWS:   rows   <= cfg_data[8:0];
        idd_pkg::REG_COLS:   cols   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // effective image size: zero acts as one, oversize clamps to the maximum
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic [TW-1:0] total;

  always_comb begin
    if (rows == 9'd0) nr = RW'(1);
    else if (32'(rows) > MAX_ROWS) nr = RW'(MAX_ROWS);
    else nr = RW'(rows);
    if (cols == 9'd0) nc = CW'(1);
    else if (32'(cols) > MAX_COLS) nc = CW'(MAX_COLS);
    else nc = CW'(cols);
  end
  assign total = TW'(TW'(nr) * TW'(nc));

  idd_pkg::state_t state, state_next;

  logic             sel;          // store holding the current image
  logic [AW-1:0]    load_index;
  logic [AW-1:0]    read_index;
  logic [AW-1:0]    rd_addr;      // held read address while waiting
  logic             rd_last;
  logic [TW-1:0]    k;            // copy pass counter
  logic [AW-1:0]    idx;          // stencil center
  logic [RW-1:0]    r;
  logic [CW-1:0]    c;
  logic [2:0]       t;            // tap counter
  logic [9:0]       sweep_cnt;
  logic [PW-1:0]    u;
  logic signed [ACW-1:0] acc;
  logic signed [PRW-1:0] prod;

  logic             slot_free;
  logic             emit;         // a result is loaded into the output slot
  logic             in_acc;
  logic             run_trivial;
  logic             row_end;
  logic             frame_end;
  logic             last_sweep;

  assign slot_free   = !out_valid || !out_stall;
  assign emit        = slot_free && (state == idd_pkg::ST_RD_WAIT ||
                                     state == idd_pkg::ST_ACK);
  assign in_stall    = (state != idd_pkg::ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign run_trivial = (nr < RW'(3)) || (nc < CW'(3)) || (sweeps == 10'd0);
  assign row_end     = (c == nc - CW'(2));
  assign frame_end   = row_end && (r == nr - RW'(2));
  assign last_sweep  = (sweep_cnt + 10'd1 == sweeps);

  // wrapped load and read positions
  logic [AW-1:0] ld0, rd0;
  logic [TW-1:0] ld_inc, rd_inc;
  assign ld0    = (TW'(load_index) >= total) ? '0 : load_index;
  assign rd0    = (TW'(read_index) >= total) ? '0 : read_index;
  assign ld_inc = TW'(ld0) + TW'(1);
  assign rd_inc = TW'(rd0) + TW'(1);

  // frame store ports: reads always hit the current store
  logic          wr_en, wr_sel;
  logic [AW-1:0] wr_addr, raddr;
  logic [PW-1:0] wr_data, rd_a, rd_b, rdata;
  logic [PW-1:0] v_sat;

  assign rdata = sel ? rd_b : rd_a;

  always_comb begin
    raddr = rd_addr;
    case (state)
      idd_pkg::ST_IDLE: raddr = rd0;
      idd_pkg::ST_COPY: raddr = k[AW-1:0];
      idd_pkg::ST_STEN: begin
        case (t)
          idd_pkg::TAP_UP:    raddr = idx - AW'(nc);
          idd_pkg::TAP_LEFT:  raddr = idx - AW'(1);
          idd_pkg::TAP_RIGHT: raddr = idx + AW'(1);
          idd_pkg::TAP_DOWN:  raddr = idx + AW'(nc);
          default:            raddr = idx;
        endcase
      end
      default: raddr = rd_addr;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_sel  = ~sel;
    wr_addr = idx;
    wr_data = v_sat;
    case (state)
      idd_pkg::ST_IDLE: begin
        wr_en   = in_acc && (cmd == idd_pkg::CMD_LOAD);
        wr_sel  = sel;
        wr_addr = ld0;
        wr_data = {pixel_in, {FRAC_BITS{1'b0}}};
      end
      idd_pkg::ST_COPY: begin
        wr_en   = (k != '0);
        wr_addr = AW'(k - TW'(1));
        wr_data = rdata;
      end
      idd_pkg::ST_WR: wr_en = 1'b1;
      default: ;
    endcase
  end

  idd_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_frame_a (
    .clk(clk), .we(wr_en && !wr_sel), .waddr(wr_addr), .wdata(wr_data),
    .raddr(raddr), .rdata(rd_a)
  );
  idd_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_frame_b (
    .clk(clk), .we(wr_en && wr_sel), .waddr(wr_addr), .wdata(wr_data),
    .raddr(raddr), .rdata(rd_b)
  );

  // update: u + floor(prod / 2^16), saturated to the pixel range
  logic signed [PRW-1:0] v_full;
  assign v_full = $signed({{(PRW-PW){1'b0}}, u}) + (prod >>> 16);
  always_comb begin
    if (v_full < 0) v_sat = '0;
    else if (v_full > $signed({{(PRW-PW){1'b0}}, {PW{1'b1}}})) v_sat = '1;
    else v_sat = v_full[PW-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      idd_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            idd_pkg::CMD_RUN:  state_next = run_trivial ? idd_pkg::ST_ACK
                                                        : idd_pkg::ST_COPY;
            idd_pkg::CMD_READ: state_next = idd_pkg::ST_RD_WAIT;
            default: ;
          endcase
        end
      end
      idd_pkg::ST_RD_WAIT: if (slot_free) state_next = idd_pkg::ST_IDLE;
      idd_pkg::ST_ACK:     if (slot_free) state_next = idd_pkg::ST_IDLE;
      idd_pkg::ST_COPY:    if (k == total) state_next = idd_pkg::ST_STEN;
      idd_pkg::ST_STEN:    if (t == idd_pkg::TAP_DONE) state_next = idd_pkg::ST_MUL;
      idd_pkg::ST_MUL:     state_next = idd_pkg::ST_WR;
      idd_pkg::ST_WR: begin
        if (frame_end && last_sweep) state_next = idd_pkg::ST_ACK;
        else state_next = idd_pkg::ST_STEN;
      end
      default: state_next = idd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= idd_pkg::ST_IDLE;
    else state <= state_next;
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sel        <= 1'b0;
      load_index <= '0;
      read_index <= '0;
      out_valid  <= 1'b0;
      k          <= '0;
      t          <= '0;
      sweep_cnt  <= '0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        idd_pkg::ST_IDLE: begin
          if (in_acc) begin
            case (cmd)
              idd_pkg::CMD_LOAD:
                load_index <= (ld_inc >= total) ? '0 : ld_inc[AW-1:0];
              idd_pkg::CMD_RUN: begin
                read_index <= '0;
                k          <= '0;
              end
              idd_pkg::CMD_READ: begin
                rd_addr    <= rd0;
                rd_last    <= (rd_inc == total);
                read_index <= (rd_inc >= total) ? '0 : rd_inc[AW-1:0];
              end
              default: ;
            endcase
          end
        end
        idd_pkg::ST_RD_WAIT: begin
          if (slot_free) begin
            kind       <= idd_pkg::KIND_PIXEL;
            pixel_out  <= rdata[PW-1:FRAC_BITS];
            last_pixel <= rd_last;
          end
        end
        idd_pkg::ST_ACK: begin
          if (slot_free) begin
            kind       <= idd_pkg::KIND_ACK;
            pixel_out  <= '0;
            last_pixel <= 1'b0;
          end
        end
        idd_pkg::ST_COPY: begin
          k <= k + TW'(1);
          if (k == total) begin
            idx       <= AW'(nc) + AW'(1);
            r         <= RW'(1);
            c         <= CW'(1);
            t         <= '0;
            sweep_cnt <= '0;
          end
        end
        idd_pkg::ST_STEN: begin
          t <= t + 3'd1;
          // data of tap t-1 arrives this cycle
          if (t == idd_pkg::TAP_UP) begin
            u   <= rdata;
            acc <= ACW'(0) - $signed({1'b0, rdata, 2'b00});
          end else if (t != idd_pkg::TAP_CENTER) begin
            acc <= acc + $signed({3'b000, rdata});
          end
        end
        idd_pkg::ST_MUL: prod <= $signed({1'b0, kappa}) * acc;
        idd_pkg::ST_WR: begin
          t <= '0;
          if (frame_end) begin
            sel       <= ~sel;
            sweep_cnt <= sweep_cnt + 10'd1;
            idx       <= AW'(nc) + AW'(1);
            r         <= RW'(1);
            c         <= CW'(1);
          end else if (row_end) begin
            idx <= idx + AW'(3);
            r   <= r + RW'(1);
            c   <= CW'(1);
          end else begin
            idx <= idx + AW'(1);
            c   <= c + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // a result is only produced from the read-wait or acknowledge states
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == idd_pkg::ST_RD_WAIT || state == idd_pkg::ST_ACK))
    else $error("result raised outside a result state");

  // stencil writes stay inside the image, off its first row and column
  assert property (@(posedge clk) disable iff (rst)
    (state == idd_pkg::ST_WR) |-> (TW'(idx) < total && r != '0 && c != '0))
    else $error("stencil write outside image");

  // input is only taken while idle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> $past(state == idd_pkg::ST_IDLE))
    else $error("item accepted while busy");

  // the store select only flips at the end of a sweep
  assert property (@(posedge clk) disable iff (rst)
    (sel != $past(sel)) |-> $past(state == idd_pkg::ST_WR && frame_end))
    else $error("store select flipped mid sweep");

endmodule
`default_nettype wire
